[rtl/core/bplc_pkg.sv]
// ----------------------------------------------------------------------------
// bplc_pkg
// Shared types and constants of the button press length classifier: event
// codes, register indexes, reset values and the structs passed between units.
// ----------------------------------------------------------------------------
package bplc_pkg;

   localparam int TIME_W      = 32;
   localparam int LIMIT_W     = 16;
   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int RSP_DEPTH   = 2;

   // Result event codes.
   localparam logic [1:0] EV_ON         = 2'd0;
   localparam logic [1:0] EV_LONG       = 2'd1;
   localparam logic [1:0] EV_EXTRA_LONG = 2'd2;
   localparam logic [1:0] EV_OFF        = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LEVEL  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_VALID_MS  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_MS       = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXTRA_LONG_MS = 8'd3;

   // Reset values of the configuration registers.
   localparam logic               RST_ACTIVE_LEVEL  = 1'b0;
   localparam logic [LIMIT_W-1:0] RST_MIN_VALID_MS  = 16'd50;
   localparam logic [LIMIT_W-1:0] RST_LONG_MS       = 16'd1000;
   localparam logic [LIMIT_W-1:0] RST_EXTRA_LONG_MS = 16'd3000;

   typedef struct packed {
      logic               active_level;
      logic [LIMIT_W-1:0] min_valid_ms;
      logic [LIMIT_W-1:0] long_ms;
      logic [LIMIT_W-1:0] extra_long_ms;
   } cfg_type;

   typedef struct packed {
      logic              pressing;
      logic [TIME_W-1:0] press_start;
      logic              long_mark;
      logic              extra_mark;
   } press_state_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic       last;
   } rsp_item_type;

   // Results produced by one sample: count (0 to 2) and the items in order.
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item0;
      rsp_item_type item1;
   } decision_type;

endpackage

[rtl/core/bplc_classify.sv]
// ----------------------------------------------------------------------------
// bplc_classify
// Combinational press classification of one sample: next press state and the
// result events that the sample produces.
// ----------------------------------------------------------------------------
module bplc_classify (
   input  bplc_pkg::cfg_type                   cfg,
   input  bplc_pkg::press_state_type           state,
   input  logic                                level,
   input  logic [bplc_pkg::TIME_W-1:0]         time_ms,
   output bplc_pkg::press_state_type           state_next,
   output bplc_pkg::decision_type              decision
);
   import bplc_pkg::*;

   logic              active;
   logic [TIME_W-1:0] elapsed;
   logic              reach_extra;
   logic              reach_long;
   logic              reach_min;

   // Elapsed time wraps with the timestamp.
   assign active      = (level == cfg.active_level);
   assign elapsed     = time_ms - state.press_start;
   assign reach_extra = elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.extra_long_ms};
   assign reach_long  = elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.long_ms};
   assign reach_min   = elapsed >= {{(TIME_W-LIMIT_W){1'b0}}, cfg.min_valid_ms};

   always_comb begin
      state_next               = state;
      decision.count           = 2'd0;
      decision.item0.event_res = EV_OFF;
      decision.item0.last      = 1'b1;
      decision.item1.event_res = EV_OFF;
      decision.item1.last      = 1'b1;
      if (active) begin
         if (!state.pressing) begin
            state_next.pressing    = 1'b1;
            state_next.press_start = time_ms;
         end else if (reach_extra) begin
            if (!state.extra_mark) begin
               decision.count           = 2'd1;
               decision.item0.event_res = EV_EXTRA_LONG;
            end
            state_next.extra_mark = 1'b1;
            state_next.long_mark  = 1'b0;
         end else if (reach_long) begin
            state_next.long_mark = 1'b1;
         end
      end else if (state.pressing) begin
         if (reach_min) begin
            if (!state.extra_mark) begin
               decision.count           = 2'd2;
               decision.item0.event_res = state.long_mark ? EV_LONG : EV_ON;
               decision.item0.last      = 1'b0;
            end else begin
               decision.count = 2'd1;
            end
            state_next.long_mark  = 1'b0;
            state_next.extra_mark = 1'b0;
         end
         // A release that comes too soon keeps the marks.
         state_next.pressing = 1'b0;
      end
   end

endmodule

[rtl/core/bplc_rsp_buf.sv]
// ----------------------------------------------------------------------------
// bplc_rsp_buf
// Two-slot result buffer. Takes up to two results per cycle and hands them
// out one per transfer, oldest first.
// ----------------------------------------------------------------------------
module bplc_rsp_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop,
   input  logic [1:0]            push_count,
   input  bplc_pkg::rsp_item_type push0,
   input  bplc_pkg::rsp_item_type push1,
   output bplc_pkg::rsp_item_type head,
   output logic [1:0]            count
);
   import bplc_pkg::*;

   rsp_item_type slot_ff [RSP_DEPTH];
   rsp_item_type slot_in [RSP_DEPTH];
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic [1:0]   base;

   assign head  = slot_ff[0];
   assign count = count_ff;
   assign base  = count_ff - {1'b0, pop};

   always_comb begin
      slot_in[0] = pop ? slot_ff[1] : slot_ff[0];
      slot_in[1] = slot_ff[1];
      if (base == 2'd0) begin
         if (push_count != 2'd0) slot_in[0] = push0;
         if (push_count == 2'd2) slot_in[1] = push1;
      end else if (base == 2'd1) begin
         if (push_count != 2'd0) slot_in[1] = push0;
      end
      count_in = base + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result buffer overfilled");

   a_partner_queued: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd0 && !slot_ff[0].last) |-> (count_ff == 2'd2 && slot_ff[1].last))
      else $error("non-final result without its final partner");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != 2'd0)
      else $error("pop from empty result buffer");

endmodule

[rtl/core/button_press_length_classifier.sv]
// ----------------------------------------------------------------------------
// button_press_length_classifier
// Classifies button presses from timestamped level samples into ON, LONG,
// EXTRA_LONG and OFF events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_level, req_time_ms
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_event_res, rsp_last
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
//  A sample is registered and classified from that register once the
//  two-slot output buffer has room for all of its results. One sample per
//  cycle is taken while req_stall is low; a sample whose results do not fit
//  holds the input register until the buffer can take them, and results
//  drain at one per cycle while rsp_stall is low. Synchronous reset clears
//  the press state, loads the CSR reset values; csr_ready is always high.
// ----------------------------------------------------------------------------
module button_press_length_classifier #(
   parameter int CSR_INDEX_W = bplc_pkg::CSR_INDEX_W
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_level,
   input  logic [bplc_pkg::TIME_W-1:0]     req_time_ms,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_event_res,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [CSR_INDEX_W-1:0]          csr_index,
   input  logic [bplc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import bplc_pkg::*;

   cfg_type           cfg_ff;
   cfg_type           cfg_in;
   press_state_type   state_ff;
   press_state_type   state_next;
   decision_type      decision;
   rsp_item_type      head;
   logic [1:0]        count;
   logic              pop;
   logic              fits;
   logic              proc;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_level_ff;
   logic [TIME_W-1:0] s1_time_ff;
   logic [2:0]        fill;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INDEX_W'(CSR_ACTIVE_LEVEL):  cfg_in.active_level  = csr_wdata[0];
            CSR_INDEX_W'(CSR_MIN_VALID_MS):  cfg_in.min_valid_ms  = csr_wdata;
            CSR_INDEX_W'(CSR_LONG_MS):       cfg_in.long_ms       = csr_wdata;
            CSR_INDEX_W'(CSR_EXTRA_LONG_MS): cfg_in.extra_long_ms = csr_wdata;
            default:                         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level  <= RST_ACTIVE_LEVEL;
         cfg_ff.min_valid_ms  <= RST_MIN_VALID_MS;
         cfg_ff.long_ms       <= RST_LONG_MS;
         cfg_ff.extra_long_ms <= RST_EXTRA_LONG_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The registered sample is classified once the buffer has room for all
   // of its results, counting the one leaving this cycle.
   assign pop       = (count != 2'd0) && !rsp_stall;
   assign fill      = {1'b0, count} - {2'b0, pop} + {1'b0, decision.count};
   assign fits      = fill <= 3'(RSP_DEPTH);
   assign proc      = s1_valid_ff && fits;
   assign req_stall = s1_valid_ff && !fits;
   assign s1_valid_in = req_valid || (s1_valid_ff && !proc);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_level_ff <= req_level;
         s1_time_ff  <= req_time_ms;
      end
   end

   bplc_classify u_classify (
      .cfg        (cfg_ff),
      .state      (state_ff),
      .level      (s1_level_ff),
      .time_ms    (s1_time_ff),
      .state_next (state_next),
      .decision   (decision)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (proc) begin
         state_ff <= state_next;
      end
   end

   bplc_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .pop        (pop),
      .push_count (proc ? decision.count : 2'd0),
      .push0      (decision.item0),
      .push1      (decision.item1),
      .head       (head),
      .count      (count)
   );

   assign rsp_valid     = count != 2'd0;
   assign rsp_event_res = head.event_res;
   assign rsp_last      = head.last;

   a_release_only: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff.pressing) |-> $past(proc && s1_level_ff != cfg_ff.active_level))
      else $error("press ended without a released sample");

   a_extra_emits: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff.extra_mark) |-> $past(proc && decision.count == 2'd1
                                           && decision.item0.event_res == EV_EXTRA_LONG))
      else $error("extra-long mark set without an EXTRA_LONG event");

   a_stall_with_results: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled while no result is waiting");

endmodule

[verif/button_press_length_classifier_test.sv]
// ----------------------------------------------------------------------------
// button_press_length_classifier_test
// Self-checking testbench for the button press length classifier. Timestamped
// level samples are sent as presses built around the configured limits, mixed
// with stray samples. An in-bench model of the press state predicts the event
// stream, and every result transfer is checked against it in order. The run
// goes through several limit settings and four mixes of sender idling and
// receiver stalls.
// ----------------------------------------------------------------------------
module button_press_length_classifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bplc_pkg::*;

   // Cycles to let pass after the last expected result before the block is
   // taken as idle.
   localparam int SETTLE_CYCLES = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_UNUSED = CSR_INDEX_W'(CSR_EXTRA_LONG_MS + 1);

   typedef struct packed {
      logic [1:0] ev;
      logic       last;
   } press_event_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_level;
   logic [TIME_W-1:0]      req_time_ms;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_event_res;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   // Shadow copy of the registers and the press state.
   logic               pressed_level;
   logic [LIMIT_W-1:0] min_ms;
   logic [LIMIT_W-1:0] long_limit;
   logic [LIMIT_W-1:0] extra_limit;
   logic               held_down;
   logic [TIME_W-1:0]  down_since;
   logic               long_seen;
   logic               extra_sent;

   press_event_type pending_events[$];
   press_event_type oldest;

   int idle_pct;
   int stall_pct;
   int error_count;
   int samples_sent;
   int events_checked;
   int csr_writes;
   int limit_settings;
   int event_count[4];
   logic [TIME_W-1:0] wall_ms;

   button_press_length_classifier dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_level     (req_level),
      .req_time_ms   (req_time_ms),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_event_res (rsp_event_res),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("button_press_length_classifier_test: errors");
      $finish;
   end

   // Updates the press state for one accepted sample and queues the events it
   // causes. Returns 0 for a release while nothing is held, which the block
   // ignores.
   function automatic bit classify_sample(logic lvl, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] held_ms;
      logic [1:0]        evs[$];
      press_event_type   item;
      held_ms = now - down_since;
      if (lvl == pressed_level) begin
         if (!held_down) begin
            held_down = 1'b1;
            down_since = now;
         end else if (held_ms >= TIME_W'(extra_limit)) begin
            // The extra-long check wins and cancels the long mark.
            if (!extra_sent) evs.push_back(EV_EXTRA_LONG);
            extra_sent = 1'b1;
            long_seen = 1'b0;
         end else if (held_ms >= TIME_W'(long_limit)) begin
            long_seen = 1'b1;
         end
      end else if (held_down) begin
         // A release that is too short leaves both marks as they were.
         if (held_ms >= TIME_W'(min_ms)) begin
            if (!extra_sent) evs.push_back(long_seen ? EV_LONG : EV_ON);
            evs.push_back(EV_OFF);
            long_seen = 1'b0;
            extra_sent = 1'b0;
         end
         held_down = 1'b0;
      end else begin
         return 1'b0;
      end
      foreach (evs[i]) begin
         item.ev = evs[i];
         item.last = (i == evs.size() - 1);
         pending_events.push_back(item);
      end
      return 1'b1;
   endfunction

   // Hold time near one of the limits, or an arbitrary one now and then.
   function automatic logic [TIME_W-1:0] pick_hold();
      logic [TIME_W-1:0] limit_ms;
      case ($urandom_range(2))
         0: limit_ms = TIME_W'(min_ms);
         1: limit_ms = TIME_W'(long_limit);
         default: limit_ms = TIME_W'(extra_limit);
      endcase
      case ($urandom_range(5))
         0: return limit_ms - 1;
         1: return limit_ms;
         2: return limit_ms + 1;
         3: return $urandom_range(0, 70000);
         4: return limit_ms + $urandom_range(0, 400);
         default: return ($urandom_range(15) == 0) ? $urandom : $urandom_range(0, 4000);
      endcase
   endfunction

   task automatic send_sample(logic lvl, logic [TIME_W-1:0] t);
      int gap = 0;
      while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_level   <= lvl;
      req_time_ms <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (classify_sample(lvl, t)) samples_sent++;
   endtask

   // Stops the sender and waits until every expected event has been seen.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ACTIVE_LEVEL:  pressed_level = data[0];
         CSR_MIN_VALID_MS:  min_ms = data;
         CSR_LONG_MS:       long_limit = data;
         CSR_EXTRA_LONG_MS: extra_limit = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic configure(logic lvl, logic [LIMIT_W-1:0] mn, logic [LIMIT_W-1:0] lg,
                            logic [LIMIT_W-1:0] xl);
      logic [CSR_DATA_W-1:0] junk;
      wait_idle();
      junk = CSR_DATA_W'($urandom);
      // Upper data bits of the level register are expected to be dropped, and
      // a write to an unused index is expected to change nothing.
      csr_write(CSR_ACTIVE_LEVEL, {junk[CSR_DATA_W-1:1], lvl});
      csr_write(CSR_MIN_VALID_MS, mn);
      csr_write(CSR_LONG_MS, lg);
      csr_write(CSR_EXTRA_LONG_MS, xl);
      csr_write(CSR_INDEX_W'($urandom_range(CSR_FIRST_UNUSED, 2**CSR_INDEX_W - 1)), ~junk);
      csr_valid <= 1'b0;
      limit_settings++;
      @(posedge clock);
   endtask

   // One press built around the limits, or now and then a stray sample.
   task automatic random_press();
      logic [TIME_W-1:0] t0;
      logic [TIME_W-1:0] off;
      logic [TIME_W-1:0] hold_max;
      int n_held;
      if ($urandom_range(9) == 0) begin
         send_sample(1'($urandom_range(1)), $urandom);
         return;
      end
      t0 = ($urandom_range(3) == 0) ? $urandom : wall_ms + $urandom_range(1, 5000);
      n_held = $urandom_range(0, 4);
      hold_max = '0;
      send_sample(pressed_level, t0);
      repeat (n_held) begin
         off = pick_hold();
         if (off < hold_max) off = hold_max + $urandom_range(0, 50);
         hold_max = off;
         send_sample(pressed_level, t0 + off);
      end
      off = pick_hold();
      if (off < hold_max && $urandom_range(3) != 0) off = hold_max + $urandom_range(0, 3);
      send_sample(!pressed_level, t0 + off);
      if ($urandom_range(7) == 0) send_sample(!pressed_level, t0 + off + 1);
      wall_ms = t0 + off;
   endtask

   // Presses of each kind under the reset values of the registers.
   task automatic test_directed_defaults();
      logic dn;
      logic up;
      dn = pressed_level;
      up = !pressed_level;
      send_sample(up, 32'd0);                    // release with nothing held
      send_sample(dn, 32'd100);                  // short press
      send_sample(dn, 32'd120);
      send_sample(up, 32'd160);
      send_sample(dn, 32'd1000);                 // long press
      send_sample(dn, 32'd2000);
      send_sample(up, 32'd2100);
      send_sample(dn, 32'd5000);                 // extra long, fired only once
      send_sample(dn, 32'd8000);
      send_sample(dn, 32'd9000);
      send_sample(up, 32'd9500);
      send_sample(dn, 32'd10000);                // release one tick too early
      send_sample(up, 32'd10049);
      send_sample(dn, 32'd20000);                // release exactly at the minimum
      send_sample(up, 32'd20050);
      send_sample(dn, 32'hFFFF_FFF0);            // press across the timestamp wrap
      send_sample(up, 32'h0000_0040);
      send_sample(dn, 32'h8000_0000);            // extra long, then a too short release
      send_sample(dn, 32'h8000_0BB8);
      send_sample(up, 32'h8000_0000);
      send_sample(dn, 32'hFFFF_FFFF);            // carried mark leaves only OFF
      send_sample(up, 32'h0000_0063);
      wall_ms = 32'h0000_0063;
   endtask

   task automatic test_limit_extremes();
      configure(1'b1, 16'd0, 16'd0, 16'd0);
      repeat (25) random_press();
      configure(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      repeat (25) random_press();
      // Long limit under the minimum, so too short releases can carry marks.
      configure(1'b1, 16'hFFFF, 16'd0, 16'hFFFF);
      repeat (25) random_press();
   endtask

   task automatic test_random_traffic(int sender_idle, int receiver_stall, int n_items);
      int goal = samples_sent + n_items;
      int next_cfg = samples_sent;
      idle_pct = sender_idle;
      stall_pct = receiver_stall;
      while (samples_sent < goal) begin
         if (samples_sent >= next_cfg) begin
            case ($urandom_range(4))
               0: configure(1'($urandom_range(1)), RST_MIN_VALID_MS, RST_LONG_MS,
                            RST_EXTRA_LONG_MS);
               1: configure(1'($urandom_range(1)), LIMIT_W'($urandom_range(0, 200)),
                            LIMIT_W'($urandom_range(0, 1500)),
                            LIMIT_W'($urandom_range(0, 4000)));
               2: configure(1'($urandom_range(1)), LIMIT_W'($urandom_range(500, 2000)),
                            LIMIT_W'($urandom_range(0, 400)),
                            LIMIT_W'($urandom_range(1000, 5000)));
               3: configure(1'($urandom_range(1)), LIMIT_W'($urandom_range(0, 3)),
                            LIMIT_W'($urandom_range(0, 3)),
                            LIMIT_W'($urandom_range(0, 3)));
               default: configure(1'($urandom_range(1)),
                                  LIMIT_W'($urandom_range(65000, 65535)),
                                  LIMIT_W'($urandom_range(0, 65535)),
                                  LIMIT_W'($urandom_range(65000, 65535)));
            endcase
            next_cfg = samples_sent + $urandom_range(60, 140);
         end
         random_press();
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Each result transfer is matched against the oldest expected event.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_events.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: expected none, got event %0d last %0b",
                     $time, rsp_event_res, rsp_last);
         end else begin
            oldest = pending_events.pop_front();
            events_checked++;
            event_count[oldest.ev]++;
            if (rsp_event_res !== oldest.ev) begin
               error_count++;
               $display("%0t: event_res mismatch: expected %0d, got %0d",
                        $time, oldest.ev, rsp_event_res);
            end
            if (rsp_last !== oldest.last) begin
               error_count++;
               $display("%0t: last mismatch: expected %0b, got %0b",
                        $time, oldest.last, rsp_last);
            end
         end
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_level   <= 1'b0;
      req_time_ms <= '0;
      rsp_stall   <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= '0;
      csr_wdata   <= '0;
      idle_pct = 0;
      stall_pct = 0;
      error_count = 0;
      samples_sent = 0;
      events_checked = 0;
      csr_writes = 0;
      limit_settings = 0;
      wall_ms = '0;
      foreach (event_count[i]) event_count[i] = 0;
      pressed_level = RST_ACTIVE_LEVEL;
      min_ms = RST_MIN_VALID_MS;
      long_limit = RST_LONG_MS;
      extra_limit = RST_EXTRA_LONG_MS;
      held_down = 1'b0;
      down_since = '0;
      long_seen = 1'b0;
      extra_sent = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_defaults();
      test_limit_extremes();
      test_random_traffic(0, 0, 350);
      test_random_traffic(88, 0, 350);
      test_random_traffic(0, 88, 350);
      test_random_traffic(33, 33, 350);
      wait_idle();

      $display("Covered %0d classified samples and %0d checked events (on %0d, long %0d,",
               samples_sent, events_checked, event_count[EV_ON], event_count[EV_LONG]);
      $display("extra long %0d, off %0d) over %0d limit settings and %0d register writes.",
               event_count[EV_EXTRA_LONG], event_count[EV_OFF], limit_settings, csr_writes);
      if (error_count == 0) begin
         $display("button_press_length_classifier_test: clean");
      end else begin
         $display("button_press_length_classifier_test: errors");
      end
      $finish;
   end

endmodule
